// ===== sv/spdr_pkg.sv =====
// shared types and constants of the surplus power dimmer regulator
package spdr_pkg;

  // router modes
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_AUTO    = 3'd1;
  localparam logic [2:0] MODE_ECO     = 3'd2;
  localparam logic [2:0] MODE_OFFGRID = 3'd3;
  localparam logic [2:0] MODE_MANUAL  = 3'd4;
  localparam logic [2:0] MODE_BOOST   = 3'd5;

  // regulator state classes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INC  = 3'd1;
  localparam logic [2:0] ST_DEC  = 3'd2;
  localparam logic [2:0] ST_MAX  = 3'd3;
  localparam logic [2:0] ST_MIN  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_MANUAL = 2'd1;
  localparam logic [1:0] CFG_GAIN   = 2'd2;
  localparam logic [1:0] CFG_DBAND  = 2'd3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WATT_W = 18;
  localparam int PCT_W = 7;
  localparam int TGT_W = 15;

  // serial divider: 32-bit dividend, one quotient bit per cycle
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // source of a new level for the apply operation
  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_MANUAL,
    SEL_FULL,
    SEL_TARGET,
    SEL_DOWN5,
    SEL_DOWN10,
    SEL_QUOT,
    SEL_OFF_ENTRY
  } apply_sel_t;

  typedef struct packed {
    logic       capture;
    logic       mark_mode;
    logic       apply_en;
    apply_sel_t apply_sel;
    logic       div_start;
    logic       div_step;
    logic       load_out;
  } spdr_cmd_t;

  typedef struct packed {
    logic       mode_changed;
    logic       entry_act;
    apply_sel_t entry_sel;
    logic       step_act;
    apply_sel_t step_sel;
    logic       step_div;
  } spdr_sts_t;

endpackage

// ===== sv/spdr_ctrl.sv =====
// sequencer of the dimmer regulator: entry action, step, serial divide, result
module spdr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  spdr_pkg::spdr_sts_t sts,
  output spdr_pkg::spdr_cmd_t cmd
);
  import spdr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENTRY,
    S_PLAN,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   emit_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign emit_ok   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.apply_sel = SEL_ZERO;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ENTRY;
        end
      end
      S_ENTRY: begin
        cmd.mark_mode = 1'b1;
        if (sts.mode_changed && sts.entry_act) begin
          cmd.apply_en  = 1'b1;
          cmd.apply_sel = sts.entry_sel;
        end
        state_nxt = S_PLAN;
      end
      S_PLAN: begin
        if (sts.step_div) begin
          cmd.div_start = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_DIV;
        end else begin
          cmd.apply_en  = sts.step_act;
          cmd.apply_sel = sts.step_sel;
          state_nxt     = S_EMIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.apply_en  = 1'b1;
        cmd.apply_sel = SEL_QUOT;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ok) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/spdr_dp.sv =====
// datapath of the dimmer regulator: config registers, level state, divider, result
module spdr_dp #(
  parameter int LEVEL_MIN = 0,
  parameter int LEVEL_MAX = 100
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [spdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spdr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic signed [spdr_pkg::WATT_W-1:0]  in_grid_watts,
  input  logic signed [spdr_pkg::WATT_W-1:0]  in_solar_watts,
  input  logic signed [spdr_pkg::WATT_W-1:0]  in_load_watts,
  output logic [spdr_pkg::PCT_W-1:0]          out_dimmer_level,
  output logic                                out_level_changed,
  output logic [2:0]                          out_regulator_state,
  input  spdr_pkg::spdr_cmd_t                 cmd,
  output spdr_pkg::spdr_sts_t                 sts
);
  import spdr_pkg::*;

  localparam logic signed [33:0] LVL_LO = 34'(LEVEL_MIN * 256);
  localparam logic signed [33:0] LVL_HI = 34'(LEVEL_MAX * 256);
  localparam logic [PCT_W-1:0]   PCT_LO = PCT_W'(LEVEL_MIN);
  localparam logic [PCT_W-1:0]   PCT_HI = PCT_W'(LEVEL_MAX);

  // configuration
  logic [2:0]        mode_r;
  logic [PCT_W-1:0]  manual_r;
  logic [15:0]       gain_r;
  logic [15:0]       dband_r;

  // regulator state
  logic [TGT_W-1:0]  target_r;
  logic [PCT_W-1:0]  applied_r;
  logic [2:0]        last_mode_r;
  logic [PCT_W-1:0]  prev_r;

  // captured item
  logic signed [WATT_W-1:0] grid_r, solar_r, load_r;

  // divider
  logic [31:0] num_r, num_nxt;
  logic [19:0] rem_r, rem_nxt;
  logic [18:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;

  // result
  logic [PCT_W-1:0] lvl_out_r;
  logic             chg_out_r;
  logic [2:0]       st_out_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OFF;
      manual_r <= '0;
      gain_r   <= 16'd160;
      dband_r  <= 16'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_wdata[2:0];
        CFG_MANUAL: manual_r <= cfg_wdata[PCT_W-1:0];
        CFG_GAIN:   gain_r   <= cfg_wdata;
        CFG_DBAND:  dband_r  <= cfg_wdata;
        default:    mode_r   <= mode_r;
      endcase
    end
  end

  // comparisons against the dead band
  logic signed [18:0] grid_x, db_x;
  logic signed [21:0] solar_x, load_x, diff, db5_x;
  logic [18:0]        db5;
  logic               grid_hi, grid_lo, solar_hi;

  assign grid_x   = {grid_r[WATT_W-1], grid_r};
  assign db_x     = {3'b000, dband_r};
  assign grid_hi  = grid_x > db_x;
  assign grid_lo  = grid_x < -db_x;
  assign solar_hi = $signed({solar_r[WATT_W-1], solar_r}) > db_x;

  // 4*solar - 5*load works in 1/5 W units, so 80% of solar is exact
  assign solar_x = {{4{solar_r[WATT_W-1]}}, solar_r};
  assign load_x  = {{4{load_r[WATT_W-1]}}, load_r};
  assign diff    = (solar_x <<< 2) - ((load_x <<< 2) + load_x);
  assign db5     = {1'b0, dband_r, 2'b00} + {3'b000, dband_r};
  assign db5_x   = {3'b000, db5};

  // status toward the controller
  always_comb begin
    sts              = '0;
    sts.entry_sel    = SEL_ZERO;
    sts.step_sel     = SEL_ZERO;
    sts.mode_changed = (mode_r != last_mode_r);
    case (mode_r)
      MODE_OFF: begin
        sts.entry_act = 1'b1;
        sts.entry_sel = SEL_OFF_ENTRY;
        sts.step_act  = (applied_r != '0);
        sts.step_sel  = SEL_ZERO;
      end
      MODE_AUTO: begin
        sts.step_div = grid_hi || grid_lo;
      end
      MODE_ECO: begin
        sts.step_div = grid_hi;
      end
      MODE_OFFGRID: begin
        if (solar_hi) begin
          if (diff > db5_x) begin
            sts.step_div = 1'b1;
          end else if (diff < -db5_x) begin
            sts.step_act = 1'b1;
            sts.step_sel = SEL_DOWN5;
          end else begin
            sts.step_act = 1'b1;
            sts.step_sel = SEL_TARGET;
          end
        end else if (target_r != '0) begin
          sts.step_act = 1'b1;
          sts.step_sel = SEL_DOWN10;
        end
      end
      MODE_MANUAL: begin
        sts.entry_act = 1'b1;
        sts.entry_sel = SEL_MANUAL;
        sts.step_act  = (applied_r != manual_r);
        sts.step_sel  = SEL_MANUAL;
      end
      MODE_BOOST: begin
        sts.entry_act = 1'b1;
        sts.entry_sel = SEL_FULL;
        sts.step_act  = (applied_r != 7'd100);
        sts.step_sel  = SEL_FULL;
      end
      default: begin
        sts.step_act = 1'b0;
      end
    endcase
  end

  // divider operands and steps
  logic [15:0] gain_eff;
  logic [17:0] grid_mag;
  logic [20:0] div_sub;
  logic [19:0] rem_sh;

  assign gain_eff = (gain_r < 16'd16) ? 16'd16 : gain_r;
  assign grid_mag = grid_r[WATT_W-1] ? 18'(-grid_r) : 18'(grid_r);
  assign rem_sh   = {rem_r[18:0], num_r[31]};
  assign div_sub  = {1'b0, rem_sh} - {2'b00, den_r};

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    if (cmd.div_start) begin
      rem_nxt = '0;
      case (mode_r)
        MODE_AUTO: begin
          num_nxt = {2'b00, grid_mag, 12'd0};
          den_nxt = {3'b000, gain_eff};
          neg_nxt = !grid_r[WATT_W-1];
        end
        MODE_ECO: begin
          num_nxt = {2'b00, grid_r[16:0], 13'd0};
          den_nxt = {2'b00, gain_eff, 1'b0} + {3'b000, gain_eff};
          neg_nxt = 1'b1;
        end
        default: begin
          num_nxt = {diff[20:0], 11'd0};
          den_nxt = {1'b0, gain_eff, 2'b00} + {3'b000, gain_eff};
          neg_nxt = 1'b0;
        end
      endcase
    end else if (cmd.div_step) begin
      rem_nxt = div_sub[20] ? rem_sh : div_sub[19:0];
      num_nxt = {num_r[30:0], !div_sub[20]};
    end
  end

  // apply operation: pick a level, clamp, round half up
  logic signed [33:0] tgt_x, quot_x, lvl, lvl_cl;
  logic [15:0]        lvl_rnd;
  logic [PCT_W-1:0]   applied_new;

  assign tgt_x  = {19'd0, target_r};
  assign quot_x = neg_r ? -$signed({2'b00, num_r}) : $signed({2'b00, num_r});

  always_comb begin
    case (cmd.apply_sel)
      SEL_ZERO:      lvl = '0;
      SEL_OFF_ENTRY: lvl = '0;
      SEL_MANUAL:    lvl = {19'd0, manual_r, 8'd0};
      SEL_FULL:      lvl = 34'sd25600;
      SEL_TARGET:    lvl = tgt_x;
      SEL_DOWN5:     lvl = tgt_x - 34'sd1280;
      SEL_DOWN10:    lvl = tgt_x - 34'sd2560;
      SEL_QUOT:      lvl = tgt_x + quot_x;
      default:       lvl = tgt_x;
    endcase
    if (lvl < LVL_LO) begin
      lvl_cl = LVL_LO;
    end else if (lvl > LVL_HI) begin
      lvl_cl = LVL_HI;
    end else begin
      lvl_cl = lvl;
    end
  end

  assign lvl_rnd     = {1'b0, lvl_cl[TGT_W-1:0]} + 16'd128;
  assign applied_new = lvl_rnd[14:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      applied_r   <= '0;
      last_mode_r <= MODE_OFF;
    end else begin
      if (cmd.apply_en) begin
        // entering off forces the target to zero after the clamp
        target_r  <= (cmd.apply_sel == SEL_OFF_ENTRY) ? '0 : lvl_cl[TGT_W-1:0];
        applied_r <= applied_new;
      end
      if (cmd.mark_mode) begin
        last_mode_r <= mode_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    if (cmd.capture) begin
      grid_r  <= in_grid_watts;
      solar_r <= in_solar_watts;
      load_r  <= in_load_watts;
      prev_r  <= applied_r;
    end
  end

  // state class of the finished item
  always_comb begin
    case (mode_r)
      MODE_AUTO, MODE_ECO: begin
        if (applied_r >= PCT_HI)      st_nxt = ST_MAX;
        else if (applied_r <= PCT_LO) st_nxt = ST_MIN;
        else if (grid_lo)             st_nxt = ST_INC;
        else if (grid_hi)             st_nxt = ST_DEC;
        else                          st_nxt = ST_IDLE;
      end
      MODE_OFFGRID: begin
        if (applied_r >= PCT_HI)      st_nxt = ST_MAX;
        else if (applied_r <= PCT_LO) st_nxt = ST_MIN;
        else if (solar_hi)            st_nxt = ST_INC;
        else                          st_nxt = ST_DEC;
      end
      MODE_BOOST: st_nxt = ST_MAX;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      lvl_out_r <= applied_r;
      chg_out_r <= (applied_r != prev_r);
      st_out_r  <= st_nxt;
    end
  end

  assign out_dimmer_level    = lvl_out_r;
  assign out_level_changed   = chg_out_r;
  assign out_regulator_state = st_out_r;

endmodule

// ===== sv/surplus_power_dimmer_regulator_unit.sv =====
// top level of the surplus power dimmer regulator
//
// one item on the in_ channel is one measurement of grid, solar and load power
// in whole signed watts; each item yields exactly one item on the out_ channel
// with the dimmer percent, a changed flag and the regulator state class.
// both channels are valid/ready; an item moves when valid and ready are high.
// cfg_ writes (mode, manual percent, gain, dead band) take effect at once and
// are meant to be done while the block is idle.
// after accept an item passes the entry and plan steps and, when the mode
// divides by the gain (auto, eco, offgrid raise), the divide and finish steps,
// before its result is loaded; the gain division is a restoring divider giving
// one quotient bit per cycle over all 32 bits of the dividend.
// in_ready is high only while no item is in work; a result waiting in the
// output register does not block the next accept, but a stalled receiver
// holds the block at its final step until the waiting item is taken.
// a mode change runs the new mode's entry action at the start of the next item.
// reset (rst_n low, synchronous) restores the config reset values, clears the
// target and the driven percent and drops out_valid.
module surplus_power_dimmer_regulator_unit #(
  parameter int LEVEL_MIN = 0,
  parameter int LEVEL_MAX = 100
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [spdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spdr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // measurement items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [spdr_pkg::WATT_W-1:0]  in_grid_watts,
  input  logic signed [spdr_pkg::WATT_W-1:0]  in_solar_watts,
  input  logic signed [spdr_pkg::WATT_W-1:0]  in_load_watts,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [spdr_pkg::PCT_W-1:0]          out_dimmer_level,
  output logic                                out_level_changed,
  output logic [2:0]                          out_regulator_state
);
  import spdr_pkg::*;

  spdr_cmd_t cmd;
  spdr_sts_t sts;

  // sequencer: entry step, plan step, serial divide, result load
  spdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // registers, level arithmetic, divider and output register
  spdr_dp #(
    .LEVEL_MIN (LEVEL_MIN),
    .LEVEL_MAX (LEVEL_MAX)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_grid_watts       (in_grid_watts),
    .in_solar_watts      (in_solar_watts),
    .in_load_watts       (in_load_watts),
    .out_dimmer_level    (out_dimmer_level),
    .out_level_changed   (out_level_changed),
    .out_regulator_state (out_regulator_state),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

// ===== sv/spdr_checker.sv =====
// port-level checks of the dimmer regulator and their binding to the top level
module spdr_checker #(
  parameter int LEVEL_MIN = 0,
  parameter int LEVEL_MAX = 100
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_we,
  input logic [spdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [spdr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [spdr_pkg::WATT_W-1:0]  in_grid_watts,
  input logic signed [spdr_pkg::WATT_W-1:0]  in_solar_watts,
  input logic signed [spdr_pkg::WATT_W-1:0]  in_load_watts,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [spdr_pkg::PCT_W-1:0]          out_dimmer_level,
  input logic                                out_level_changed,
  input logic [2:0]                          out_regulator_state
);
  import spdr_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dimmer_level)
      && $stable(out_regulator_state) && $stable(out_level_changed))
    else $error("result changed while stalled");

  // the driven percent never leaves the limits
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dimmer_level <= PCT_W'(LEVEL_MAX)
      && out_dimmer_level >= PCT_W'(LEVEL_MIN))
    else $error("dimmer level outside limits");

  // the at-maximum class only with the level at the upper limit
  a_max_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_regulator_state == ST_MAX |-> out_dimmer_level >= PCT_W'(LEVEL_MAX))
    else $error("at maximum reported below the upper limit");

  // the at-minimum class only with the level at the lower limit
  a_min_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_regulator_state == ST_MIN |-> out_dimmer_level <= PCT_W'(LEVEL_MIN))
    else $error("at minimum reported above the lower limit");

  // one item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

endmodule

bind surplus_power_dimmer_regulator_unit spdr_checker #(
  .LEVEL_MIN (LEVEL_MIN),
  .LEVEL_MAX (LEVEL_MAX)
) u_spdr_checker (.*);
